// ===== rtl/core/ecd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecd_pkg: shared types and constants of the echo escape decoder
// Payload structs, the queue entry that links front and back, and the
// escape-letter lookup.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_COUNT_W     = 16;

  localparam logic [7:0] CHR_BSL   = 8'h5C;  // '\\'
  localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHR_SEVEN = 8'h37;  // '7'
  localparam logic [7:0] CHR_C     = 8'h63;  // 'c'
  localparam logic [7:0] BEL_BYTE  = 8'h07;
  localparam logic [7:0] VT_BYTE   = 8'h0B;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } ecd_in_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   has_byte;
    logic                   end_marker;
    logic                   nl_suppress;
    logic [OUT_COUNT_W-1:0] byte_count;
    logic                   last_of_run;
  } ecd_out_t;

  // One classified input item: up to two bytes, optionally closing the string
  typedef struct packed {
    logic [7:0] byte0;
    logic       has0;
    logic [7:0] byte1;
    logic       has1;
    logic       is_end;
    logic       inhibit;
  } ecd_op_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } ecd_esc_t;

  // Single-byte escapes: \a \b \f \n \r \t \v and the doubled backslash
  function automatic ecd_esc_t esc_lookup(input logic [7:0] b);
    ecd_esc_t r;
    r.hit = 1'b1;
    unique case (b)
      8'h61:   r.value = BEL_BYTE;  // a
      8'h62:   r.value = 8'h08;     // b
      8'h66:   r.value = 8'h0C;     // f
      8'h6E:   r.value = 8'h0A;     // n
      8'h72:   r.value = 8'h0D;     // r
      8'h74:   r.value = 8'h09;     // t
      8'h76:   r.value = VT_BYTE;   // v
      CHR_BSL: r.value = CHR_BSL;
      default: begin
        r.hit   = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_SEVEN);
  endfunction

endpackage

// ===== rtl/core/ecd_front.sv =====
// ----------------------------------------------------------------------------
// ecd_front: escape parser
// Accepts input bytes, tracks the escape state and pushes one queue entry
// per item that produces output.
// ----------------------------------------------------------------------------
module ecd_front import ecd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  ecd_in_t in_data,
  input  logic    q_full,
  output logic    q_push,
  output ecd_op_t q_op
);

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_BSL  = 2'd1,
    MODE_OCT1 = 2'd2,
    MODE_OCT2 = 2'd3
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [8:0] oct_r, oct_nxt;
  logic       inh_r, inh_nxt;
  ecd_op_t    op;
  ecd_esc_t   esc;
  logic       accept;
  logic       b_oct;
  logic [7:0] b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign b_oct    = is_octal(b);
  assign esc      = esc_lookup(b);

  always_comb begin
    mode_nxt = mode_r;
    oct_nxt  = oct_r;
    inh_nxt  = inh_r;
    op       = '0;
    if (in_data.is_end) begin
      op.is_end  = 1'b1;
      op.inhibit = inh_r;
      op.has0    = (mode_r != MODE_TEXT);
      op.byte0   = (mode_r == MODE_BSL) ? CHR_BSL : oct_r[7:0];
      mode_nxt   = MODE_TEXT;
      inh_nxt    = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_TEXT: begin
          if (b == CHR_BSL) begin
            mode_nxt = MODE_BSL;
          end else begin
            op.has0  = 1'b1;
            op.byte0 = b;
          end
        end
        MODE_BSL: begin
          mode_nxt = MODE_TEXT;
          if (esc.hit) begin
            op.has0  = 1'b1;
            op.byte0 = esc.value;
          end else if (b == CHR_C) begin
            inh_nxt = 1'b1;
          end else if (b_oct) begin
            oct_nxt  = {6'd0, b[2:0]};
            mode_nxt = MODE_OCT1;
          end else begin
            op.has0  = 1'b1;
            op.byte0 = CHR_BSL;
            op.has1  = 1'b1;
            op.byte1 = b;
          end
        end
        MODE_OCT1, MODE_OCT2: begin
          if (b_oct) begin
            oct_nxt = {oct_r[5:0], b[2:0]};
            if (mode_r == MODE_OCT1) begin
              mode_nxt = MODE_OCT2;
            end else begin
              op.has0  = 1'b1;
              op.byte0 = {oct_r[4:0], b[2:0]};
              mode_nxt = MODE_TEXT;
            end
          end else begin
            // run ends: flush value, then the byte is plain text
            op.has0  = 1'b1;
            op.byte0 = oct_r[7:0];
            if (b == CHR_BSL) begin
              mode_nxt = MODE_BSL;
            end else begin
              op.has1  = 1'b1;
              op.byte1 = b;
              mode_nxt = MODE_TEXT;
            end
          end
        end
        default: mode_nxt = MODE_TEXT;
      endcase
    end
  end

  assign q_push = accept && (op.has0 || op.is_end);
  assign q_op   = op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      oct_r  <= '0;
      inh_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      oct_r  <= oct_nxt;
      inh_r  <= inh_nxt;
    end
  end

endmodule

// ===== rtl/core/ecd_queue.sv =====
// ----------------------------------------------------------------------------
// ecd_queue: small register queue between parser and emitter
// Entries are classified items; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module ecd_queue import ecd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ecd_op_t wr_data,
  input  logic    pop,
  output ecd_op_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int AW = $clog2(DEPTH);

  ecd_op_t       mem_r [DEPTH];
  logic [AW:0]   wp_r, rp_r;
  logic [AW:0]   used;

  assign used    = wp_r - rp_r;
  assign full    = (used == (AW+1)'(DEPTH));
  assign empty   = (used == '0);
  assign rd_data = mem_r[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue pop while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (AW+1)'(DEPTH))
    else $error("queue fill level out of range");

endmodule

// ===== rtl/core/ecd_back.sv =====
// ----------------------------------------------------------------------------
// ecd_back: result emitter
// Expands each queue entry into one or two result transactions, keeps the
// saturating byte count and drives the output register.
// ----------------------------------------------------------------------------
module ecd_back import ecd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ecd_op_t  head,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output ecd_out_t out_data
);

  logic                   phase_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic                   out_valid_r;
  ecd_out_t               out_data_r, res;
  logic                   load, is_byte, last;

  assign load    = !q_empty && (!out_valid_r || out_ready);
  assign is_byte = phase_r ? head.has1 : head.has0;
  assign last    = phase_r || !head.has0 || (!head.has1 && !head.is_end);
  assign q_pop   = load && last;

  always_comb begin
    res             = '0;
    res.last_of_run = last;
    if (is_byte) begin
      res.out_byte = phase_r ? head.byte1 : head.byte0;
      res.has_byte = 1'b1;
    end else begin
      res.end_marker  = 1'b1;
      res.nl_suppress = head.inhibit;
      res.byte_count  = OUT_COUNT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= !last;
        if (!is_byte) begin
          cnt_r <= '0;
        end else if (cnt_r != '1) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // second half of an entry is only pending while that entry is still queued
  a_phase_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_empty)
    else $error("second result pending without a queued entry");
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.end_marker) |-> (out_data_r.last_of_run
                                                 && !out_data_r.has_byte))
    else $error("end result malformed");
  a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !is_byte) |=> (cnt_r == '0))
    else $error("byte count not cleared after end result");

endmodule

// ===== rtl/core/echo_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// echo_escape_decoder: echo-style backslash escape decoder
// Decodes one string byte per input transaction into output bytes and a
// closing summary result.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one string byte per transaction; is_end closes the string.
//   out_* : decoded bytes (has_byte=1), and on is_end a summary result with
//           end_marker=1, nl_suppress and the saturating byte_count.
//           last_of_run marks the final result caused by an input item.
// Path: an accepted item is written into the queue, and the emitter then
//   loads its first result into the output register.
// Throughput: one input per cycle while the queue has room; the output
//   side delivers one result per cycle while out_ready is high, so an
//   item's two results (unknown escape, octal run ended by a byte, flush
//   before end) go out in turn. Items that yield nothing are not queued.
// Reset: rst_n low returns to text mode, empties the queue, clears the
//   count, inhibit flag and out_valid.
// Stall: with out_ready low the output holds; the queue (QUEUE_DEPTH
//   entries) absorbs items, then in_ready drops until space frees.
// ----------------------------------------------------------------------------
module echo_escape_decoder import ecd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ecd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ecd_out_t out_data
);

  logic    q_full, q_empty, q_push, q_pop;
  ecd_op_t q_wr, q_rd;

  ecd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_wr)
  );

  ecd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  ecd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: echo escape decoder
// A short table of directed strings is sent first, then random escape
// sequences, under several sender and receiver idle patterns. A burst is
// sent while the output is held off, so the input stalls. Every output
// transaction is checked field by field against the typed results of the
// table rows, or else against a behavioral decoder kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench import ecd_pkg::*;;

  localparam int COUNT_W     = COUNT_WIDTH_DEF;
  localparam int PREDICT     = -1;  // table row checked against the decoder model
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_OCT1,
    MODE_OCT2
  } dec_mode_t;

  typedef struct {
    logic [7:0] in_byte;
    logic       is_end;
    int         n_res;
    ecd_out_t   r0;
    ecd_out_t   r1;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ecd_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ecd_out_t out_data;

  // decoder model state
  dec_mode_t          dec_mode;
  logic [8:0]         oct_acc;
  logic               inhibit_flag;
  logic [COUNT_W-1:0] emitted;

  ecd_out_t step_results[$];
  ecd_out_t expected_results[$];
  ecd_out_t got_exp;

  int   mismatches = 0;
  int   items_sent = 0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_req   = 1'b0;
  int   hold_left  = HOLD_CYCLES;

  logic [7:0] esc_letters[9] = '{"a", "b", "f", "n", "r", "t", "v", CHR_BSL, CHR_C};
  dir_row_t   dir_rows[25];

  echo_escape_decoder #(
    .COUNT_WIDTH(COUNT_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  function automatic ecd_out_t byte_res(input logic [7:0] b, input logic last);
    ecd_out_t r;
    r             = '0;
    r.out_byte    = b;
    r.has_byte    = 1'b1;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic ecd_out_t end_res(input logic inh, input logic [OUT_COUNT_W-1:0] cnt);
    ecd_out_t r;
    r             = '0;
    r.end_marker  = 1'b1;
    r.nl_suppress = inh;
    r.byte_count  = cnt;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t row(input logic [7:0] b, input logic e, input int n,
                                   input ecd_out_t r0 = '0, input ecd_out_t r1 = '0);
    dir_row_t d;
    d.in_byte = b;
    d.is_end  = e;
    d.n_res   = n;
    d.r0      = r0;
    d.r1      = r1;
    return d;
  endfunction

  function automatic logic oct_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_SEVEN);
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    step_results.push_back(byte_res(b, 1'b0));
    if (emitted != '1) emitted++;
  endfunction

  function automatic void text_char(input logic [7:0] b);
    if (b == CHR_BSL) dec_mode = MODE_ESC;
    else emit_byte(b);
  endfunction

  // Results of one input transaction land in step_results
  function automatic void predict_decode(input ecd_in_t it);
    logic [7:0] b;
    b = it.in_byte;
    step_results.delete();
    if (it.is_end) begin
      case (dec_mode)
        MODE_ESC:            emit_byte(CHR_BSL);
        MODE_OCT1, MODE_OCT2: emit_byte(oct_acc[7:0]);
        default: ;
      endcase
      step_results.push_back(end_res(inhibit_flag, emitted[OUT_COUNT_W-1:0]));
      dec_mode     = MODE_TEXT;
      oct_acc      = '0;
      inhibit_flag = 1'b0;
      emitted      = '0;
      return;
    end
    case (dec_mode)
      MODE_TEXT: text_char(b);
      MODE_ESC: begin
        dec_mode = MODE_TEXT;
        case (b)
          "a":     emit_byte(BEL_BYTE);
          "b":     emit_byte(8'h08);
          "f":     emit_byte(8'h0C);
          "n":     emit_byte(8'h0A);
          "r":     emit_byte(8'h0D);
          "t":     emit_byte(8'h09);
          "v":     emit_byte(VT_BYTE);
          CHR_BSL: emit_byte(CHR_BSL);
          CHR_C:   inhibit_flag = 1'b1;
          default: begin
            if (oct_digit(b)) begin
              oct_acc  = {6'd0, b[2:0]};
              dec_mode = MODE_OCT1;
            end else begin
              // unknown escape passes through as two bytes
              emit_byte(CHR_BSL);
              emit_byte(b);
            end
          end
        endcase
      end
      MODE_OCT1: begin
        if (oct_digit(b)) begin
          oct_acc  = {oct_acc[5:0], b[2:0]};
          dec_mode = MODE_OCT2;
        end else begin
          emit_byte(oct_acc[7:0]);
          dec_mode = MODE_TEXT;
          text_char(b);
        end
      end
      default: begin
        if (oct_digit(b)) begin
          oct_acc = {oct_acc[5:0], b[2:0]};
          emit_byte(oct_acc[7:0]);
          dec_mode = MODE_TEXT;
        end else begin
          emit_byte(oct_acc[7:0]);
          dec_mode = MODE_TEXT;
          text_char(b);
        end
      end
    endcase
    if (dec_mode == MODE_TEXT) oct_acc = '0;
    if (step_results.size() > 0) step_results[step_results.size()-1].last_of_run = 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] b, input logic e, input int typed_n = PREDICT,
                           input ecd_out_t r0 = '0, input ecd_out_t r1 = '0);
    ecd_in_t item;
    item.in_byte = b;
    item.is_end  = e;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_decode(item);
    if (typed_n == PREDICT) begin
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
    end else begin
      if (typed_n > 0) expected_results.push_back(r0);
      if (typed_n > 1) expected_results.push_back(r1);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Mostly well-formed escapes with random content, some noise
  task automatic send_string();
    int tokens;
    int kind;
    int t;
    tokens = $urandom_range(0, 10);
    for (t = 0; t < tokens; t++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 9: send_item(8'($urandom_range(0, 255)), 1'b0);
        3, 4: begin
          send_item(CHR_BSL, 1'b0);
          send_item(esc_letters[$urandom_range(0, 8)], 1'b0);
        end
        5: begin
          send_item(CHR_BSL, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        6, 7: begin
          send_item(CHR_BSL, 1'b0);
          repeat ($urandom_range(1, 3)) send_item(CHR_ZERO + 8'($urandom_range(0, 7)), 1'b0);
        end
        default: send_item(CHR_BSL, 1'b0);
      endcase
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_random(input int idle, input int stall, input int n_items);
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) send_string();
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endtask

  // Receiver: random stall, or a counted hold-off once it is requested
  always @(negedge clk) begin
    if (hold_req && (hold_left > 0)) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("output transaction with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        got_exp = expected_results.pop_front();
        check_field("out_byte", 32'(got_exp.out_byte), 32'(out_data.out_byte));
        check_field("has_byte", 32'(got_exp.has_byte), 32'(out_data.has_byte));
        check_field("end_marker", 32'(got_exp.end_marker), 32'(out_data.end_marker));
        check_field("nl_suppress", 32'(got_exp.nl_suppress), 32'(out_data.nl_suppress));
        check_field("byte_count", 32'(got_exp.byte_count), 32'(out_data.byte_count));
        check_field("last_of_run", 32'(got_exp.last_of_run), 32'(out_data.last_of_run));
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    dec_mode     = MODE_TEXT;
    oct_acc      = '0;
    inhibit_flag = 1'b0;
    emitted      = '0;

    dir_rows = '{
      row(8'h00, 1'b1, 1, end_res(1'b0, '0)),
      row(8'h00, 1'b0, 1, byte_res(8'h00, 1'b1)),
      row(8'hFF, 1'b0, 1, byte_res(8'hFF, 1'b1)),
      row(CHR_BSL, 1'b0, 0),
      row("a", 1'b0, 1, byte_res(BEL_BYTE, 1'b1)),
      row(CHR_BSL, 1'b0, 0),
      row("v", 1'b0, 1, byte_res(VT_BYTE, 1'b1)),
      row(CHR_BSL, 1'b0, 0),
      row(CHR_BSL, 1'b0, 1, byte_res(CHR_BSL, 1'b1)),
      row(CHR_BSL, 1'b0, 0),
      row(CHR_C, 1'b0, 0),
      // NUL after a backslash is an unknown escape
      row(CHR_BSL, 1'b0, 0),
      row(8'h00, 1'b0, 2, byte_res(CHR_BSL, 1'b0), byte_res(8'h00, 1'b1)),
      // octal 777 truncates to 8 bits
      row(CHR_BSL, 1'b0, 0),
      row("7", 1'b0, 0),
      row("7", 1'b0, 0),
      row("7", 1'b0, 1, byte_res(8'hFF, 1'b1)),
      // octal run cut short by a backslash that starts a new escape
      row(CHR_BSL, 1'b0, 0),
      row("1", 1'b0, 0),
      row("2", 1'b0, 0),
      row(CHR_BSL, 1'b0, PREDICT),
      // end flushes the pending backslash
      row(8'hA5, 1'b1, PREDICT),
      row(CHR_BSL, 1'b0, 0),
      row("5", 1'b0, 0),
      row(8'h5A, 1'b1, PREDICT)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].in_byte, dir_rows[i].is_end, dir_rows[i].n_res,
                dir_rows[i].r0, dir_rows[i].r1);

    run_random(0, 0, 460);
    run_random(51, 0, 460);
    run_random(0, 51, 460);
    run_random(8, 8, 400);

    // hold the output off while items keep coming, so in_ready drops
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (40) send_item(8'h41, 1'b0);
    send_item(8'h00, 1'b1);
    run_random(8, 8, 20);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
